// ----- rtl/skct_pkg.sv -----
package skct_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int POS_W = 8;
  localparam int POS_CMP_W = (IDX_W > POS_W) ? IDX_W : POS_W;
  localparam int KEY_W = 32;
  localparam int CNT_W = 32;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam cnt_t CNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_LOOKUP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_INS    = 2'd1,
    PH_DEL    = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef struct packed {
    op_e              operation;
    key_t             serial_number;
    logic [POS_W-1:0] position;
  } req_t;

  typedef struct packed {
    status_e status;
    key_t    key_out;
    cnt_t    repeat_count;
  } rsp_t;

  // Operation token that walks down the cell chain, one cell per cycle.
  typedef struct packed {
    logic             act;
    op_e              op;
    phase_e           phase;
    logic             full;
    key_t             key;
    logic [POS_W-1:0] pos;
    key_t             carry_key;
    cnt_t             carry_cnt;
    logic             ins;
    logic             del;
    rsp_t             res;
  } tok_t;

endpackage

// ----- rtl/skct_cell.sv -----
module skct_cell import skct_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] index,
  input  logic [OCC_W-1:0] occupancy,
  input  tok_t             tok_in,
  input  key_t             nxt_key,
  input  cnt_t             nxt_cnt,
  output key_t             cell_key,
  output cnt_t             cell_cnt,
  output tok_t             tok_out
);

  logic [OCC_W-1:0] rank;
  logic             vld;
  logic             nxt_vld;
  logic             hit;
  logic             above;
  logic             pos_match;
  cnt_t             cnt_inc;
  key_t             key_next;
  cnt_t             cnt_next;
  tok_t             tok_next;

  // Validity follows from the rank of the cell against the occupancy, which
  // stays fixed while a token is in flight.
  assign rank      = OCC_W'(index);
  assign vld       = rank < occupancy;
  assign nxt_vld   = (rank + OCC_W'(1)) < occupancy;
  assign hit       = vld && (cell_key == tok_in.key);
  assign above     = !vld || (cell_key > tok_in.key);
  assign pos_match = POS_CMP_W'(index) == POS_CMP_W'(tok_in.pos);
  assign cnt_inc   = (cell_cnt == CNT_MAX) ? cell_cnt : cell_cnt + cnt_t'(1);

  always_comb begin
    key_next = cell_key;
    cnt_next = cell_cnt;
    tok_next = tok_in;
    if (tok_in.act) begin
      unique case (tok_in.phase)
        PH_SEARCH: begin
          unique case (tok_in.op)
            OP_ADD: begin
              if (hit) begin
                cnt_next                  = cnt_inc;
                tok_next.res.repeat_count = cnt_inc;
                tok_next.res.status       = ST_OK;
                tok_next.phase            = PH_DONE;
              end else if (above) begin
                if (tok_in.full) begin
                  tok_next.res.status = ST_FULL;
                  tok_next.phase      = PH_DONE;
                end else begin
                  // Insert here and carry the old entry to the right.
                  key_next                  = tok_in.key;
                  cnt_next                  = '0;
                  tok_next.carry_key        = cell_key;
                  tok_next.carry_cnt        = cell_cnt;
                  tok_next.res.status       = ST_OK;
                  tok_next.res.repeat_count = '0;
                  tok_next.ins              = 1'b1;
                  tok_next.phase            = vld ? PH_INS : PH_DONE;
                end
              end
            end
            OP_REMOVE: begin
              if (hit) begin
                tok_next.res.repeat_count = cell_cnt;
                tok_next.res.status       = ST_OK;
                tok_next.del              = 1'b1;
                tok_next.phase            = PH_DEL;
                key_next                  = nxt_key;
                cnt_next                  = nxt_cnt;
              end else if (above) begin
                tok_next.phase = PH_DONE;
              end
            end
            OP_READ: begin
              if (pos_match) begin
                if (vld) begin
                  tok_next.res.key_out      = cell_key;
                  tok_next.res.repeat_count = cell_cnt;
                  tok_next.res.status       = ST_OK;
                end
                tok_next.phase = PH_DONE;
              end
            end
            OP_LOOKUP: begin
              if (hit) begin
                tok_next.res.repeat_count = cell_cnt;
                tok_next.res.status       = ST_OK;
                tok_next.phase            = PH_DONE;
              end else if (above) begin
                tok_next.phase = PH_DONE;
              end
            end
          endcase
        end
        PH_INS: begin
          key_next           = tok_in.carry_key;
          cnt_next           = tok_in.carry_cnt;
          tok_next.carry_key = cell_key;
          tok_next.carry_cnt = cell_cnt;
          if (!vld) begin
            tok_next.phase = PH_DONE;
          end
        end
        PH_DEL: begin
          if (vld) begin
            key_next = nxt_key;
            cnt_next = nxt_cnt;
          end
          if (!nxt_vld) begin
            tok_next.phase = PH_DONE;
          end
        end
        PH_DONE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cell_key <= key_next;
    cell_cnt <= cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.act <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

// ----- rtl/sorted_key_count_table_core.sv -----
// The accepted request is loaded into the first token register; the token walks the
// whole cell chain, one cell per cycle, and its result is registered onto rsp. No new
// item enters until the token leaves the chain and no second result waits behind rsp.
// A finished result may wait in the output register and a second one behind it.
// Reset: synchronous, empties the table at once (occupancy zero); stored keys and
// counts are not cleared and need no clearing pass.
module sorted_key_count_table_core import skct_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  tok_t             tok [CAPACITY+1];
  key_t             keys [CAPACITY];
  cnt_t             cnts [CAPACITY];
  logic [OCC_W-1:0] occupancy;
  logic             busy;
  logic             pend_vld;
  rsp_t             pend;
  logic             accept;
  logic             fin;
  logic             out_free;
  tok_t             launch;

  assign req_stall = busy || pend_vld;
  assign accept    = req_valid && !req_stall;
  assign fin       = tok[CAPACITY].act;
  assign out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    launch                  = tok[0];
    launch.act              = 1'b1;
    launch.op               = req.operation;
    launch.phase            = PH_SEARCH;
    launch.full             = occupancy == OCC_W'(CAPACITY);
    launch.key              = req.serial_number;
    launch.pos              = req.position;
    launch.ins              = 1'b0;
    launch.del              = 1'b0;
    // An add that passes every cell without a place to land met a full table.
    launch.res.status       = (req.operation == OP_ADD) ? ST_FULL : ST_NOT_FOUND;
    launch.res.key_out      = '0;
    launch.res.repeat_count = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].act <= 1'b0;
    end else if (accept) begin
      tok[0] <= launch;
    end else begin
      tok[0].act <= 1'b0;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t nk;
    cnt_t nc;
    if (i == CAPACITY - 1) begin : g_last
      assign nk = '0;
      assign nc = '0;
    end else begin : g_mid
      assign nk = keys[i+1];
      assign nc = cnts[i+1];
    end
    skct_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .index     (IDX_W'(i)),
      .occupancy (occupancy),
      .tok_in    (tok[i]),
      .nxt_key   (nk),
      .nxt_cnt   (nc),
      .cell_key  (keys[i]),
      .cell_cnt  (cnts[i]),
      .tok_out   (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      occupancy <= '0;
      rsp_valid <= 1'b0;
      pend_vld  <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (fin) begin
        busy <= 1'b0;
      end
      if (fin && tok[CAPACITY].ins) begin
        occupancy <= occupancy + OCC_W'(1);
      end else if (fin && tok[CAPACITY].del) begin
        occupancy <= occupancy - OCC_W'(1);
      end
      if (out_free) begin
        rsp_valid <= pend_vld || fin;
        pend_vld  <= pend_vld && fin;
      end else if (fin) begin
        pend_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_vld) begin
        rsp <= pend;
        if (fin) begin
          pend <= tok[CAPACITY].res;
        end
      end else if (fin) begin
        rsp <= tok[CAPACITY].res;
      end
    end else if (fin) begin
      pend <= tok[CAPACITY].res;
    end
  end

endmodule
